// ===== rtl/scc_pkg.sv =====
package scc_pkg;

	localparam int unsigned DEF_MAX_VERTICES = 1024;
	localparam int unsigned DEF_MAX_EDGES    = 4096;
	localparam int unsigned FIELD_W          = 11;

endpackage

// ===== rtl/scc_ram.sv =====
module scc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/scc_source_component_count.sv =====
// Source strongly connected component counter.
// Input channel: one directed edge per transfer (edge_from -> edge_to, flagged by
// edge_present) together with vertex_count and last. Edges are kept in
// per-vertex linked lists in on-chip RAM. Each stored edge is followed by a
// commit with in_stall high, so no new edge is taken before it is committed.
// The transfer marked last starts a Tarjan search driven by a small sequencer
// with an explicit frame stack and vertex stack; then every edge leaving a vertex
// in 1..V, with V the saturated vertex count, is walked again to mark entered
// components, and the unentered ones are counted. The sequencer waits on the
// registered read of each RAM that it uses. in_stall stays high from the last
// transfer until the next graph.
// Output channel: one transfer per graph carrying source_component_count and
// edge_overflow, held in registers; while the receiver stalls they hold steady.
// After the result transfer the per-vertex tables are swept clear, one vertex
// per cycle, before the next edge is taken.
// Reset: after arst_n the same clearing sweep runs before the first edge.
module scc_source_component_count
	import scc_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int unsigned MAX_EDGES    = DEF_MAX_EDGES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FIELD_W-1:0]   vertex_count,
	input  logic [FIELD_W-1:0]   edge_from,
	input  logic [FIELD_W-1:0]   edge_to,
	input  logic                 edge_present,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FIELD_W-1:0]   source_component_count,
	output logic                 edge_overflow
);

	localparam int unsigned VW  = $clog2(MAX_VERTICES + 1);
	localparam int unsigned VD  = MAX_VERTICES + 1;
	localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned LW  = $clog2(MAX_EDGES + 1);
	localparam int unsigned SAW = $clog2(MAX_VERTICES);
	localparam int unsigned FW  = VW + LW + VW;

	// sequencer states
	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_LOAD  = 5'd1;
	localparam logic [4:0] S_ROOT  = 5'd2;
	localparam logic [4:0] S_ROOTW = 5'd3;
	localparam logic [4:0] S_OPEN  = 5'd4;
	localparam logic [4:0] S_TOP   = 5'd5;
	localparam logic [4:0] S_TOPW  = 5'd6;
	localparam logic [4:0] S_EDGE  = 5'd7;
	localparam logic [4:0] S_EDGEW = 5'd8;
	localparam logic [4:0] S_WCHK  = 5'd9;
	localparam logic [4:0] S_FIN   = 5'd10;
	localparam logic [4:0] S_FINW  = 5'd11;
	localparam logic [4:0] S_POP   = 5'd12;
	localparam logic [4:0] S_POPW  = 5'd13;
	localparam logic [4:0] S_RET   = 5'd14;
	localparam logic [4:0] S_RETW  = 5'd15;
	localparam logic [4:0] S_MU    = 5'd16;
	localparam logic [4:0] S_MUW   = 5'd17;
	localparam logic [4:0] S_ME    = 5'd18;
	localparam logic [4:0] S_MEW   = 5'd19;
	localparam logic [4:0] S_MC    = 5'd20;
	localparam logic [4:0] S_CNT   = 5'd21;
	localparam logic [4:0] S_CNTW  = 5'd22;
	localparam logic [4:0] S_OUT   = 5'd23;

	logic [4:0] state_q;
	logic [VW-1:0] n_q, root_q, v_q, w_q, low_q, visit_q, comp_q, cu_q, cnt_q, k_q;
	logic [LW-1:0] ecount_q, link_q;
	logic [SAW:0]  fsp_q, vsp_q;
	logic          ovf_q;
	logic [VW-1:0] clr_q;

	// ram ports
	logic          ft_we;  logic [VW-1:0] ft_wa, ft_ra; logic [LW-1:0] ft_wd, ft_rd;
	logic          dn_we;  logic [VW-1:0] dn_wa, dn_ra, dn_wd, dn_rd;
	logic          co_we;  logic [VW-1:0] co_wa, co_ra, co_wd, co_rd;
	logic          ce_we;  logic [VW-1:0] ce_wa, ce_ra; logic [0:0] ce_wd, ce_rd;
	logic          et_we;  logic [EAW-1:0] et_wa, et_ra; logic [VW-1:0] et_wd, et_rd;
	logic [LW-1:0] el_wd, el_rd;
	logic          fr_we;  logic [SAW-1:0] fr_wa, fr_ra; logic [FW-1:0] fr_wd, fr_rd;
	logic          vs_we;  logic [SAW-1:0] vs_wa, vs_ra; logic [VW-1:0] vs_wd, vs_rd;

	// component_of holds 0 for pending, else component id; done means nonzero
	scc_ram #(.WIDTH(LW), .DEPTH(VD)) u_first (.clk, .wr_en(ft_we), .wr_addr(ft_wa),
		.wr_data(ft_wd), .rd_addr(ft_ra), .rd_data(ft_rd));
	scc_ram #(.WIDTH(VW), .DEPTH(VD)) u_disc (.clk, .wr_en(dn_we), .wr_addr(dn_wa),
		.wr_data(dn_wd), .rd_addr(dn_ra), .rd_data(dn_rd));
	scc_ram #(.WIDTH(VW), .DEPTH(VD)) u_comp (.clk, .wr_en(co_we), .wr_addr(co_wa),
		.wr_data(co_wd), .rd_addr(co_ra), .rd_data(co_rd));
	scc_ram #(.WIDTH(1), .DEPTH(VD)) u_ent (.clk, .wr_en(ce_we), .wr_addr(ce_wa),
		.wr_data(ce_wd), .rd_addr(ce_ra), .rd_data(ce_rd));
	scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_etgt (.clk, .wr_en(et_we), .wr_addr(et_wa),
		.wr_data(et_wd), .rd_addr(et_ra), .rd_data(et_rd));
	scc_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_elnk (.clk, .wr_en(et_we), .wr_addr(et_wa),
		.wr_data(el_wd), .rd_addr(et_ra), .rd_data(el_rd));
	scc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_frm (.clk, .wr_en(fr_we), .wr_addr(fr_wa),
		.wr_data(fr_wd), .rd_addr(fr_ra), .rd_data(fr_rd));
	scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vstk (.clk, .wr_en(vs_we),
		.wr_addr(vs_wa), .wr_data(vs_wd), .rd_addr(vs_ra), .rd_data(vs_rd));

	// pending edge: the head of edge_from is read at the transfer and linked next cycle
	logic          pend_q;
	logic [VW-1:0] pend_from_q, pend_to_q;
	logic          pend_last_q;

	logic          ld_ok, ld_fits;
	logic [VW-1:0] from_v, to_v;
	logic [VW-1:0] sat_n;
	logic          fire;
	logic          et_in;
	logic [LW-1:0] fr_next;
	logic [VW-1:0] fr_low, fr_vtx;

	assign from_v  = VW'(edge_from);
	assign to_v    = VW'(edge_to);
	assign ld_ok   = edge_present && edge_from >= FIELD_W'(1) && edge_to >= FIELD_W'(1)
		&& 32'(edge_from) <= MAX_VERTICES && 32'(edge_to) <= MAX_VERTICES;
	assign ld_fits = 32'(ecount_q) < MAX_EDGES;
	assign sat_n   = (32'(vertex_count) > MAX_VERTICES) ? VW'(MAX_VERTICES) : VW'(vertex_count);
	assign fire    = in_valid && !in_stall;
	assign in_stall = (state_q != S_LOAD) || pend_q || pend_last_q;
	assign out_valid = (state_q == S_OUT);
	assign source_component_count = FIELD_W'(cnt_q);
	assign edge_overflow = ovf_q;
	assign et_in   = (et_rd >= VW'(1)) && (et_rd <= n_q);
	assign {fr_vtx, fr_next, fr_low} = fr_rd;

	// ram port control
	always_comb begin
		ft_we = 1'b0; ft_wa = '0; ft_wd = '0; ft_ra = '0;
		dn_we = 1'b0; dn_wa = '0; dn_wd = '0; dn_ra = '0;
		co_we = 1'b0; co_wa = '0; co_wd = '0; co_ra = '0;
		ce_we = 1'b0; ce_wa = '0; ce_wd = '0; ce_ra = '0;
		et_we = 1'b0; et_wa = '0; et_wd = '0; el_wd = '0; et_ra = '0;
		fr_we = 1'b0; fr_wa = '0; fr_wd = '0; fr_ra = '0;
		vs_we = 1'b0; vs_wa = '0; vs_wd = '0; vs_ra = '0;
		unique case (state_q)
			S_CLR: begin
				ft_we = 1'b1; ft_wa = clr_q;
				dn_we = 1'b1; dn_wa = clr_q;
				co_we = 1'b1; co_wa = clr_q;
				ce_we = 1'b1; ce_wa = clr_q;
			end
			S_LOAD: begin
				// read the head for a new edge; commit the pending one
				ft_ra = from_v;
				if (pend_q) begin
					et_we = 1'b1; et_wa = EAW'(ecount_q);
					et_wd = pend_to_q; el_wd = ft_rd;
					ft_we = 1'b1; ft_wa = pend_from_q; ft_wd = ecount_q + LW'(1);
				end
			end
			S_ROOT: begin
				if (root_q <= n_q) begin
					dn_ra = root_q; ft_ra = root_q;
				end
			end
			S_OPEN: begin
				dn_we = 1'b1; dn_wa = v_q; dn_wd = visit_q;
				fr_we = 1'b1; fr_wa = SAW'(fsp_q); fr_wd = {v_q, link_q, visit_q};
				vs_we = 1'b1; vs_wa = SAW'(vsp_q); vs_wd = v_q;
			end
			S_TOP: begin
				fr_ra = SAW'(fsp_q - (SAW+1)'(1));
			end
			S_EDGE: begin
				et_ra = EAW'(link_q - LW'(1));
			end
			S_EDGEW: begin
				// advance the frame to the next edge and look up the target
				fr_we = 1'b1; fr_wa = SAW'(fsp_q - (SAW+1)'(1)); fr_wd = {v_q, el_rd, low_q};
				dn_ra = et_rd; co_ra = et_rd; ft_ra = et_rd;
			end
			S_WCHK: begin
				if (dn_rd != '0 && co_rd == '0 && dn_rd < low_q) begin
					fr_we = 1'b1; fr_wa = SAW'(fsp_q - (SAW+1)'(1));
					fr_wd = {v_q, link_q, dn_rd};
				end
			end
			S_FIN: begin
				dn_ra = v_q;
			end
			S_POP: begin
				vs_ra = SAW'(vsp_q - (SAW+1)'(1));
			end
			S_POPW: begin
				co_we = 1'b1; co_wa = vs_rd; co_wd = comp_q;
			end
			S_RET: begin
				fr_ra = SAW'(fsp_q - (SAW+1)'(2));
			end
			S_RETW: begin
				if (low_q < fr_low) begin
					fr_we = 1'b1; fr_wa = SAW'(fsp_q - (SAW+1)'(1));
					fr_wd = {fr_vtx, fr_next, low_q};
				end
			end
			S_MU: begin
				if (cu_q <= n_q) begin
					ft_ra = cu_q; co_ra = cu_q;
				end
			end
			S_ME: begin
				et_ra = EAW'(link_q - LW'(1));
			end
			S_MEW: begin
				co_ra = et_rd;
			end
			S_MC: begin
				ce_we = (w_q >= VW'(1)) && (w_q <= n_q) && (co_rd != k_q);
				ce_wa = co_rd; ce_wd = 1'b1;
			end
			S_CNT: begin
				ce_ra = cu_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; clr_q <= '0; ecount_q <= '0; ovf_q <= 1'b0;
			pend_q <= 1'b0; pend_last_q <= 1'b0; pend_from_q <= '0; pend_to_q <= '0;
			n_q <= '0; root_q <= '0; v_q <= '0; w_q <= '0; low_q <= '0; visit_q <= '0;
			comp_q <= '0; cu_q <= '0; cnt_q <= '0; k_q <= '0; link_q <= '0;
			fsp_q <= '0; vsp_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (32'(clr_q) == MAX_VERTICES) begin
						clr_q <= '0; state_q <= S_LOAD;
						ecount_q <= '0; ovf_q <= 1'b0; visit_q <= '0; comp_q <= VW'(1);
						pend_q <= 1'b0; pend_last_q <= 1'b0;
					end else begin
						clr_q <= clr_q + VW'(1);
					end
				end
				S_LOAD: begin
					if (pend_q) begin
						ecount_q <= ecount_q + LW'(1);
					end
					pend_q <= 1'b0;
					if (pend_last_q) begin
						// last edge committed, start the search
						pend_last_q <= 1'b0;
						root_q <= VW'(1); state_q <= S_ROOT;
					end else if (fire) begin
						if (ld_ok && ld_fits) begin
							pend_q <= 1'b1; pend_from_q <= from_v; pend_to_q <= to_v;
						end else if (ld_ok) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							pend_last_q <= 1'b1; n_q <= sat_n;
						end
					end
				end
				S_ROOT: begin
					if (root_q > n_q) begin
						cu_q <= VW'(1); state_q <= S_MU;
					end else begin
						state_q <= S_ROOTW;
					end
				end
				S_ROOTW: begin
					if (dn_rd != '0) begin
						root_q <= root_q + VW'(1); state_q <= S_ROOT;
					end else begin
						v_q <= root_q; link_q <= ft_rd; fsp_q <= '0; vsp_q <= '0;
						visit_q <= visit_q + VW'(1); state_q <= S_OPEN;
					end
				end
				S_OPEN: begin
					fsp_q <= fsp_q + (SAW+1)'(1); vsp_q <= vsp_q + (SAW+1)'(1);
					state_q <= S_TOP;
				end
				S_TOP: begin
					state_q <= S_TOPW;
				end
				S_TOPW: begin
					v_q <= fr_vtx; link_q <= fr_next; low_q <= fr_low;
					state_q <= (fr_next != '0) ? S_EDGE : S_FIN;
				end
				S_EDGE: begin
					state_q <= S_EDGEW;
				end
				S_EDGEW: begin
					// targets outside 1..n are skipped
					w_q <= et_rd; link_q <= el_rd;
					state_q <= et_in ? S_WCHK : S_TOP;
				end
				S_WCHK: begin
					if (dn_rd == '0) begin
						v_q <= w_q; link_q <= ft_rd;
						visit_q <= visit_q + VW'(1); state_q <= S_OPEN;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_FIN: begin
					state_q <= S_FINW;
				end
				S_FINW: begin
					state_q <= (low_q == dn_rd) ? S_POP : S_RET;
				end
				S_POP: begin
					state_q <= S_POPW;
				end
				S_POPW: begin
					vsp_q <= vsp_q - (SAW+1)'(1);
					if (vs_rd == v_q || vsp_q == (SAW+1)'(1)) begin
						comp_q <= comp_q + VW'(1); state_q <= S_RET;
					end else begin
						state_q <= S_POP;
					end
				end
				S_RET: begin
					// drop the frame; fold its low into the parent
					fsp_q <= fsp_q - (SAW+1)'(1);
					if (fsp_q == (SAW+1)'(1)) begin
						root_q <= root_q + VW'(1); state_q <= S_ROOT;
					end else begin
						state_q <= S_RETW;
					end
				end
				S_RETW: begin
					state_q <= S_TOP;
				end
				S_MU: begin
					if (cu_q > n_q) begin
						cu_q <= VW'(1); cnt_q <= '0; state_q <= S_CNT;
					end else begin
						state_q <= S_MUW;
					end
				end
				S_MUW: begin
					link_q <= ft_rd; k_q <= co_rd;
					if (ft_rd != '0) begin
						state_q <= S_ME;
					end else begin
						cu_q <= cu_q + VW'(1); state_q <= S_MU;
					end
				end
				S_ME: begin
					state_q <= S_MEW;
				end
				S_MEW: begin
					w_q <= et_rd; link_q <= el_rd; state_q <= S_MC;
				end
				S_MC: begin
					if (link_q != '0) begin
						state_q <= S_ME;
					end else begin
						cu_q <= cu_q + VW'(1); state_q <= S_MU;
					end
				end
				S_CNT: begin
					state_q <= (cu_q >= comp_q) ? S_OUT : S_CNTW;
				end
				S_CNTW: begin
					if (ce_rd == 1'b0) begin
						cnt_q <= cnt_q + VW'(1);
					end
					cu_q <= cu_q + VW'(1); state_q <= S_CNT;
				end
				S_OUT: begin
					if (!out_stall) begin
						clr_q <= '0; state_q <= S_CLR;
					end
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_scc_source_component_count.sv =====
`timescale 1ns / 1ps

module tb_scc_source_component_count;
	import scc_pkg::*;

	localparam int NV = DEF_MAX_VERTICES;
	localparam int NE = DEF_MAX_EDGES;
	localparam int FIELD_MASK = (1 << FIELD_W) - 1;

	typedef struct packed {
		logic [FIELD_W-1:0] count;
		logic               overflow;
	} graph_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [FIELD_W-1:0] vertex_count = '0;
	logic [FIELD_W-1:0] edge_from = '0;
	logic [FIELD_W-1:0] edge_to = '0;
	logic               edge_present = 1'b0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [FIELD_W-1:0] source_component_count;
	logic               edge_overflow;

	// edge list of the graph being loaded
	int            edge_src[$];
	int            edge_dst[$];
	bit            dropped_full;
	graph_result_t expected_counts[$];
	int            mismatches = 0;
	bit            calm = 1'b0;

	scc_source_component_count dut (.*);

	always #5 clk = ~clk;

	// predictor working arrays
	int  first_link[NV+1];
	int  tgt[NE];
	int  nxt[NE];
	int  disc[NV+1];
	int  comp[NV+1];
	bit  done_v[NV+1];
	bit  entered[NV+1];
	int  fr_v[NV];
	int  fr_next[NV];
	int  fr_low[NV];
	int  vstk[NV];

	function automatic graph_result_t count_sources(int n);
		graph_result_t r;
		int visits, comps, fsp, vsp, idx, w, v, lo, k, link, cnt;
		visits = 0; comps = 1; cnt = 0;
		for (int i = 0; i <= NV; i++) begin
			first_link[i] = 0; disc[i] = 0; comp[i] = 0; done_v[i] = 0; entered[i] = 0;
		end
		foreach (edge_src[i]) begin
			tgt[i] = edge_dst[i];
			nxt[i] = first_link[edge_src[i]];
			first_link[edge_src[i]] = i + 1;
		end
		if (n > NV) n = NV;
		for (int root = 1; root <= n; root++) begin
			if (disc[root] != 0) continue;
			visits++; disc[root] = visits;
			fr_v[0] = root; fr_next[0] = first_link[root]; fr_low[0] = visits;
			vstk[0] = root; fsp = 1; vsp = 1;
			while (fsp > 0) begin
				if (fr_next[fsp-1] != 0) begin
					idx = fr_next[fsp-1] - 1;
					w = tgt[idx];
					fr_next[fsp-1] = nxt[idx];
					if (w == 0 || w > n) continue;
					if (disc[w] == 0) begin
						visits++; disc[w] = visits;
						fr_v[fsp] = w; fr_next[fsp] = first_link[w]; fr_low[fsp] = visits;
						vstk[vsp] = w; fsp++; vsp++;
					end else if (!done_v[w] && disc[w] < fr_low[fsp-1]) begin
						fr_low[fsp-1] = disc[w];
					end
				end else begin
					v = fr_v[fsp-1]; lo = fr_low[fsp-1];
					if (lo == disc[v]) begin
						while (vsp > 0) begin
							vsp--; k = vstk[vsp];
							done_v[k] = 1; comp[k] = comps;
							if (k == v) break;
						end
						comps++;
					end
					fsp--;
					if (fsp > 0 && lo < fr_low[fsp-1]) fr_low[fsp-1] = lo;
				end
			end
		end
		for (int u = 1; u <= n; u++) begin
			link = first_link[u];
			while (link != 0) begin
				w = tgt[link-1]; link = nxt[link-1];
				if (w >= 1 && w <= n && comp[u] != comp[w]) entered[comp[w]] = 1;
			end
		end
		for (int c = 1; c < comps && c <= NV; c++)
			if (!entered[c]) cnt++;
		r.count = cnt[FIELD_W-1:0];
		r.overflow = dropped_full;
		return r;
	endfunction

	// one input transfer, with random idle bursts before it
	task automatic send_item(int n, int src, int dst, bit present, bit fin);
		int nn, s, d;
		nn = n & FIELD_MASK;
		s = src & FIELD_MASK;
		d = dst & FIELD_MASK;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		vertex_count <= nn[FIELD_W-1:0];
		edge_from <= s[FIELD_W-1:0];
		edge_to <= d[FIELD_W-1:0];
		edge_present <= present;
		last <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// accepted: update the edge list
		if (present && s >= 1 && s <= NV && d >= 1 && d <= NV) begin
			if (edge_src.size() < NE) begin
				edge_src = {edge_src, s};
				edge_dst = {edge_dst, d};
			end else begin
				dropped_full = 1'b1;
			end
		end
		if (fin) begin
			expected_counts = {expected_counts, count_sources(nn)};
			edge_src.delete(); edge_dst.delete(); dropped_full = 1'b0;
		end
		@(negedge clk);
	endtask

	task automatic send_edge(int src, int dst);
		send_item($urandom_range(0, 2047), src, dst, 1'b1, 1'b0);
	endtask

	// receiver stall bursts
	initial begin
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		graph_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_counts.size() == 0) begin
				$display("%t unexpected result count %0d overflow %0d", $time,
					source_component_count, edge_overflow);
				mismatches++;
			end else begin
				want = expected_counts.pop_front();
				if (source_component_count !== want.count) begin
					$display("%t count expected %0d actual %0d", $time, want.count,
						source_component_count);
					mismatches++;
				end
				if (edge_overflow !== want.overflow) begin
					$display("%t overflow expected %0d actual %0d", $time, want.overflow,
						edge_overflow);
					mismatches++;
				end
			end
		end
	end

	task automatic test_directed();
		// empty graph and zero vertices
		send_item(0, 0, 0, 1'b0, 1'b1);
		send_item(1, 0, 0, 1'b0, 1'b1);
		// self loop on the last item, then a cycle plus a tail
		send_item(1, 1, 1, 1'b1, 1'b1);
		send_edge(1, 2); send_edge(2, 3); send_edge(3, 1);
		send_item(4, 3, 4, 1'b1, 1'b1);
		// bad endpoints dropped silently, endpoint above vertex_count ignored
		send_edge(0, 2); send_edge(2047, 1); send_edge(1025, 3); send_edge(1, 0);
		send_edge(1, 2047); send_edge(1024, 1); send_edge(2, 1);
		send_item(2, 0, 0, 1'b0, 1'b0);
		send_item(2, 1, 2, 1'b1, 1'b1);
		// vertex_count saturates, all bits of the count field
		send_edge(1024, 1024); send_edge(1023, 1024);
		send_item(2047, 1, 1024, 1'b1, 1'b1);
		send_item(1024, 0, 0, 1'b0, 1'b1);
	endtask

	task automatic test_random(int items);
		int sent, len, n, kind;
		sent = 0;
		while (sent < items) begin
			if (sent > items * 4 / 5) calm = 1'b1;
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 24);
			len = $urandom_range(0, 30);
			for (int i = 0; i < len; i++) begin
				kind = $urandom_range(0, 19);
				if (kind == 0)
					send_item($urandom, $urandom, $urandom, 1'b0, 1'b0);
				else if (kind == 1)
					send_item($urandom, $urandom, $urandom, 1'b1, 1'b0);
				else
					send_edge($urandom_range(1, (n < 1) ? 1 : (n > NV ? NV : n) + 1),
						$urandom_range(1, (n < 1) ? 1 : (n > NV ? NV : n) + 1));
				sent++;
			end
			send_item(n, $urandom_range(1, 30), $urandom_range(1, 30), $urandom_range(0, 1), 1'b1);
			sent++;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(1925);
		in_valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#200ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
